// File: rtl/tcw_pkg.sv
// tcw_pkg: shared types and constants of the tcp congestion window control block
// used by all tcw modules; no dependencies

package tcw_pkg;

  localparam int unsigned MAX_WINDOW_SEG   = 1024;
  localparam int unsigned INIT_THRESH_SEG  = 64;

  localparam logic [10:0] MAX_WINDOW        = 11'(MAX_WINDOW_SEG);
  localparam logic [10:0] INITIAL_THRESHOLD = 11'(INIT_THRESH_SEG);

  localparam logic [15:0] RTT_RESET       = 16'd500;
  localparam logic [15:0] RTT_TIMEOUT_ADD = 16'd200;
  localparam logic [15:0] RTT_MAX         = 16'hFFFF;
  localparam logic [7:0]  COUNT_MAX       = 8'hFF;

  localparam logic [15:0] SEG_SIZE_RESET  = 16'd1024;
  localparam logic [7:0]  TO_LIMIT_RESET  = 8'd5;

  // request kinds
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic CFG_SEGMENT_SIZE  = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

  // state snapshot and inputs carried from the update stage to the burst stage
  typedef struct packed {
    logic [31:0] remaining_bytes;
    logic [15:0] peer_window;
    logic [10:0] cwnd;
    logic [10:0] ssthresh;
    logic [15:0] rtt;
    logic        give_up;
  } stage_t;

endpackage

// File: rtl/tcw_req_if.sv
// tcw_req_if: valid/ready channel carrying one congestion event
// plain logic payload; no package dependencies

interface tcw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] remaining_bytes;
  logic [15:0] peer_window;
  logic [15:0] elapsed_ms;

  modport source (output valid, req_type, remaining_bytes, peer_window, elapsed_ms,
                  input ready);
  modport sink   (input valid, req_type, remaining_bytes, peer_window, elapsed_ms,
                  output ready);
endinterface

// File: rtl/tcw_rsp_if.sv
// tcw_rsp_if: valid/ready channel carrying one congestion result
// plain logic payload; no package dependencies

interface tcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] burst_bytes;
  logic        blocked;
  logic        give_up;
  logic [10:0] window_segments;
  logic [10:0] slow_start_threshold;
  logic [15:0] rtt_estimate;
  logic [16:0] timeout_ms;

  modport source (output valid, burst_bytes, blocked, give_up, window_segments,
                  slow_start_threshold, rtt_estimate, timeout_ms,
                  input ready);
  modport sink   (input valid, burst_bytes, blocked, give_up, window_segments,
                  slow_start_threshold, rtt_estimate, timeout_ms,
                  output ready);
endinterface

// File: rtl/tcp_congestion_window_control.sv
// tcp_congestion_window_control: tahoe-style congestion window control, top level
// the state update stage feeds the burst stage, which forms the window times segment size product
// throughput: one request per cycle while the result channel is not stalled by rsp.ready
// reset: synchronous, window 1 segment, threshold 64, rtt 500 ms, timeout count 0,
// segment size 1024, timeout limit 5; depends on tcw_pkg, tcw_req_if, tcw_rsp_if

module tcp_congestion_window_control (
  input  logic         clk,
  input  logic         rst,
  tcw_req_if.sink      req,
  tcw_rsp_if.source    rsp,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0]     segment_size;
  logic [7:0]      timeout_limit;
  logic            st_valid;
  logic            st_ready;
  tcw_pkg::stage_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size  <= tcw_pkg::SEG_SIZE_RESET;
      timeout_limit <= tcw_pkg::TO_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::CFG_SEGMENT_SIZE:  segment_size  <= cfg_data;
        tcw_pkg::CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tcw_update u_update (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .req_type        (req.req_type),
    .remaining_bytes (req.remaining_bytes),
    .peer_window     (req.peer_window),
    .elapsed_ms      (req.elapsed_ms),
    .timeout_limit   (timeout_limit),
    .st_valid        (st_valid),
    .st_ready        (st_ready),
    .st              (st)
  );

  tcw_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .st_valid     (st_valid),
    .st_ready     (st_ready),
    .st           (st),
    .segment_size (segment_size),
    .rsp          (rsp)
  );

endmodule

// File: rtl/tcw_update.sv
// tcw_update: congestion state registers and their per-event update
// registers the new state and the event fields into the stage register; uses tcw_pkg

module tcw_update (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [31:0]       remaining_bytes,
  input  logic [15:0]       peer_window,
  input  logic [15:0]       elapsed_ms,
  input  logic [7:0]        timeout_limit,
  output logic              st_valid,
  input  logic              st_ready,
  output tcw_pkg::stage_t   st
);

  logic [10:0] cwnd, cwnd_next;
  logic [10:0] ssthresh, ssthresh_next;
  logic [15:0] rtt, rtt_next;
  logic [7:0]  timeout_count, timeout_count_next;

  logic [11:0] grown;
  logic [18:0] rtt_x7;
  logic [16:0] rtt_smooth;
  logic [16:0] rtt_backoff;
  logic        accept;

  assign in_ready = !st_valid || st_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cwnd_next          = cwnd;
    ssthresh_next      = ssthresh;
    rtt_next           = rtt;
    timeout_count_next = timeout_count;

    grown       = (cwnd >= ssthresh) ? {1'b0, cwnd} + 12'd1 : {cwnd, 1'b0};
    rtt_x7      = {rtt, 3'b000} - {3'b000, rtt};
    rtt_smooth  = {1'b0, rtt_x7[18:3]} + {4'b0000, elapsed_ms[15:3]};
    rtt_backoff = {1'b0, rtt} + {1'b0, tcw_pkg::RTT_TIMEOUT_ADD};

    unique case (req_type)
      tcw_pkg::REQ_START: begin
        timeout_count_next = '0;
      end
      tcw_pkg::REQ_ACK: begin
        timeout_count_next = '0;
        cwnd_next = (grown > {1'b0, tcw_pkg::MAX_WINDOW}) ? tcw_pkg::MAX_WINDOW
                                                          : grown[10:0];
        rtt_next  = rtt_smooth[16] ? tcw_pkg::RTT_MAX : rtt_smooth[15:0];
      end
      tcw_pkg::REQ_TIMEOUT: begin
        if (timeout_count != tcw_pkg::COUNT_MAX) begin
          timeout_count_next = timeout_count + 8'd1;
        end
        ssthresh_next = (cwnd > 11'd1) ? {1'b0, cwnd[10:1]} : 11'd1;
        cwnd_next     = 11'd1;
        rtt_next      = rtt_backoff[16] ? tcw_pkg::RTT_MAX : rtt_backoff[15:0];
      end
      default: begin
        // unused kind leaves the state alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cwnd          <= 11'd1;
      ssthresh      <= tcw_pkg::INITIAL_THRESHOLD;
      rtt           <= tcw_pkg::RTT_RESET;
      timeout_count <= '0;
      st_valid      <= 1'b0;
    end else begin
      if (accept) begin
        cwnd          <= cwnd_next;
        ssthresh      <= ssthresh_next;
        rtt           <= rtt_next;
        timeout_count <= timeout_count_next;
        st_valid      <= 1'b1;
      end else if (st_ready) begin
        st_valid      <= 1'b0;
      end
    end
  end

  // snapshot of the state after this event
  always_ff @(posedge clk) begin
    if (accept) begin
      st.remaining_bytes <= remaining_bytes;
      st.peer_window     <= peer_window;
      st.cwnd            <= cwnd_next;
      st.ssthresh        <= ssthresh_next;
      st.rtt             <= rtt_next;
      st.give_up         <= (timeout_count_next >= timeout_limit);
    end
  end

endmodule

// File: rtl/tcw_burst.sv
// tcw_burst: burst length computation and the result register
// takes the stage snapshot from tcw_update; uses tcw_pkg

module tcw_burst (
  input  logic              clk,
  input  logic              rst,
  input  logic              st_valid,
  output logic              st_ready,
  input  tcw_pkg::stage_t   st,
  input  logic [15:0]       segment_size,
  tcw_rsp_if.source         rsp
);

  logic [26:0] window_bytes;
  logic [31:0] peer_bound;
  logic [31:0] burst;
  logic        accept;

  assign st_ready = !rsp.valid || rsp.ready;
  assign accept   = st_valid && st_ready;

  always_comb begin
    window_bytes = {16'd0, st.cwnd} * {11'd0, segment_size};
    peer_bound   = (st.remaining_bytes < {16'd0, st.peer_window}) ? st.remaining_bytes
                                                                  : {16'd0, st.peer_window};
    burst        = (peer_bound < {5'd0, window_bytes}) ? peer_bound : {5'd0, window_bytes};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.burst_bytes          <= burst;
      rsp.blocked              <= (st.peer_window == 16'd0);
      rsp.give_up              <= st.give_up;
      rsp.window_segments      <= st.cwnd;
      rsp.slow_start_threshold <= st.ssthresh;
      rsp.rtt_estimate         <= st.rtt;
      rsp.timeout_ms           <= {st.rtt, 1'b0};
    end
  end

endmodule
